FILE: hw/rtl/sequence_reorder_window_defines.svh
// Assertion macros shared by the reorder window RTL.
`ifndef SEQUENCE_REORDER_WINDOW_DEFINES_SVH
`define SEQUENCE_REORDER_WINDOW_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property once reset is released.
`define SRW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sequence reorder window check failed");
// Check a property at every edge, reset included.
`define SRW_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sequence reorder window reset check failed");
`else
`define SRW_ASSERT(lbl, clk, rst_n, prop)
`define SRW_ASSERT_RST(lbl, clk, prop)
`endif

`endif

FILE: hw/rtl/srw_pkg.sv
package srw_pkg;

    // Field widths of one packet word
    localparam int SEQ_W    = 32;
    localparam int PRICE_W  = 64;
    localparam int QTY_W    = 32;
    localparam int STAMP_W  = 63;
    localparam int FLAG_W   = 3;
    localparam int STATUS_W = 2;

    // Stream packing
    localparam int FIELDS_W   = SEQ_W + PRICE_W + QTY_W + STAMP_W;
    localparam int DATA_W     = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W      = DATA_W - FIELDS_W;
    localparam int IN_USER_W  = FLAG_W;
    localparam int OUT_USER_W = STATUS_W + FLAG_W;

    // Bit offsets inside tdata
    localparam int PRICE_LSB = SEQ_W;
    localparam int QTY_LSB   = PRICE_LSB + PRICE_W;
    localparam int STAMP_LSB = QTY_LSB + QTY_W;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_RELEASE = 2'd0,
        STATUS_STALE   = 2'd1,
        STATUS_BEYOND  = 2'd2
    } t_status;

    // One ring slot as held in memory
    typedef struct packed {
        logic                      valid;
        logic [FLAG_W-1:0]         flags;
        logic [STAMP_W-1:0]        stamp;
        logic [QTY_W-1:0]          qty;
        logic signed [PRICE_W-1:0] price;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One result word
    typedef struct packed {
        t_status                   status;
        logic [SEQ_W-1:0]          seq;
        logic signed [PRICE_W-1:0] price;
        logic [QTY_W-1:0]          qty;
        logic [STAMP_W-1:0]        stamp;
        logic [FLAG_W-1:0]         flags;
        logic                      last;
    } t_result;

    // Result handed from the controller to the output register
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLASSIFY,
        ST_LOOKUP,
        ST_RELEASE
    } t_state;

endpackage

FILE: hw/rtl/srw_ram.sv
module srw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/srw_ctrl.sv
module srw_ctrl import srw_pkg::*; #(
    parameter int WINDOW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [SEQ_W-1:0]          i_seq,
    input  t_entry                    i_pay,
    input  logic                      i_push_ready,
    output t_push                     o_push,
    output logic                      o_ram_we,
    output logic [$clog2(WINDOW)-1:0] o_ram_waddr,
    output t_entry                    o_ram_wdata,
    output logic                      o_ram_re,
    output logic [$clog2(WINDOW)-1:0] o_ram_raddr,
    input  t_entry                    i_ram_rdata
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int SUM_W  = SLOT_W + 1;

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [SEQ_W-1:0]    r_expected, n_expected;
    logic [SLOT_W-1:0]   r_clr_addr, n_clr_addr;
    logic [SEQ_W-1:0]    r_seq, n_seq;
    logic [SEQ_W-1:0]    r_offset, n_offset;
    t_entry              r_pay, n_pay;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    t_result             r_pend, n_pend;

    logic                w_stale;
    logic                w_drop;
    logic [SUM_W-1:0]    w_sum;
    logic [SLOT_W-1:0]   w_slot;
    logic [SLOT_W-1:0]   w_head_inc;
    logic                w_at_head;

    function automatic t_result drop_result(t_status status, logic [SEQ_W-1:0] seq);
        t_result res;
        res        = '0;
        res.status = status;
        res.seq    = seq;
        res.last   = 1'b1;
        return res;
    endfunction

    function automatic t_result release_result(t_entry ent, logic [SEQ_W-1:0] seq);
        t_result res;
        res.status = STATUS_RELEASE;
        res.seq    = seq;
        res.price  = ent.price;
        res.qty    = ent.qty;
        res.stamp  = ent.stamp;
        res.flags  = ent.flags;
        res.last   = 1'b0;
        return res;
    endfunction

    // Classify the offset and map it onto the ring
    assign w_stale    = r_offset[SEQ_W-1];
    assign w_drop     = w_stale || (r_offset >= SEQ_W'(WINDOW));
    assign w_sum      = {1'b0, r_head} + {1'b0, r_offset[SLOT_W-1:0]};
    assign w_slot     = (w_sum >= SUM_W'(WINDOW)) ? SLOT_W'(w_sum - SUM_W'(WINDOW))
                                                  : w_sum[SLOT_W-1:0];
    assign w_head_inc = (r_head == SLOT_W'(WINDOW - 1)) ? '0 : r_head + 1'b1;
    assign w_at_head  = (r_slot == r_head);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == SLOT_W'(WINDOW - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) n_state = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                if (!w_drop) n_state = ST_LOOKUP;
                else if (i_push_ready) n_state = ST_IDLE;
            end
            ST_LOOKUP: begin
                if (i_ram_rdata.valid) begin
                    if (i_push_ready) n_state = ST_IDLE;
                end else if (w_at_head) begin
                    n_state = ST_RELEASE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RELEASE: begin
                if (i_push_ready && !i_ram_rdata.valid) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Outputs, memory accesses and datapath updates
    always_comb begin
        n_head      = r_head;
        n_expected  = r_expected;
        n_clr_addr  = r_clr_addr;
        n_seq       = r_seq;
        n_offset    = r_offset;
        n_pay       = r_pay;
        n_slot      = r_slot;
        n_pend      = r_pend;
        o_ready     = 1'b0;
        o_push      = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_slot;
        o_ram_wdata = r_pay;
        o_ram_re    = 1'b0;
        o_ram_raddr = w_slot;
        unique case (r_state)
            ST_CLEAR: begin
                // sweep every slot to invalid
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr_addr;
                o_ram_wdata = '0;
                n_clr_addr  = r_clr_addr + 1'b1;
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_seq    = i_seq;
                    n_offset = i_seq - r_expected;
                    n_pay    = i_pay;
                end
            end
            ST_CLASSIFY: begin
                if (w_drop) begin
                    o_push.valid = i_push_ready;
                    o_push.res   = drop_result(w_stale ? STATUS_STALE : STATUS_BEYOND, r_seq);
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = w_slot;
                    n_slot      = w_slot;
                end
            end
            ST_LOOKUP: begin
                if (i_ram_rdata.valid) begin
                    // duplicate: keep the stored packet
                    o_push.valid = i_push_ready;
                    o_push.res   = drop_result(STATUS_STALE, r_seq);
                end else if (w_at_head) begin
                    // new packet is the head: release it, fetch the next slot
                    n_pend      = release_result(r_pay, r_expected);
                    n_head      = w_head_inc;
                    n_expected  = r_expected + 1'b1;
                    o_ram_re    = 1'b1;
                    o_ram_raddr = w_head_inc;
                end else begin
                    // park the packet in its slot
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_slot;
                    o_ram_wdata = r_pay;
                end
            end
            ST_RELEASE: begin
                if (i_push_ready) begin
                    o_push.valid    = 1'b1;
                    o_push.res      = r_pend;
                    o_push.res.last = !i_ram_rdata.valid;
                    if (i_ram_rdata.valid) begin
                        // drain the head slot and look one further
                        o_ram_we    = 1'b1;
                        o_ram_waddr = r_head;
                        o_ram_wdata = '0;
                        n_pend      = release_result(i_ram_rdata, r_expected);
                        n_head      = w_head_inc;
                        n_expected  = r_expected + 1'b1;
                        o_ram_re    = 1'b1;
                        o_ram_raddr = w_head_inc;
                    end
                end
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_head     <= '0;
            r_expected <= '0;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_expected <= n_expected;
            r_clr_addr <= n_clr_addr;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_seq    <= n_seq;
        r_offset <= n_offset;
        r_pay    <= n_pay;
        r_slot   <= n_slot;
        r_pend   <= n_pend;
    end

endmodule

FILE: hw/rtl/sequence_reorder_window.sv
// Sequence reorder window: puts sequenced packets back in order.
// Input stream (s_axis) carries one packet word; output stream (m_axis)
// carries result words: released packets in sequence order, or one drop
// word for a stale, duplicate or out-of-window packet. tlast marks the
// final word caused by one input packet.
// A stale or out-of-window packet is dropped after classification; a duplicate
// or a parked packet also takes a ring lookup. The release loop reads one ring
// slot a cycle while the output register takes words, through the single read
// port of the slot memory.
// A packet that fills a gap but not the head gives no output word.
// After reset the controller sweeps all WINDOW slots to invalid, one slot a
// cycle, and s_axis_tready stays low until the sweep is done; head and expected
// sequence return to zero.
// Results pass through an output register, so a stalled receiver holds the
// current word and the controller waits before its next word; an input
// packet can still be taken while a finished word waits to be collected.
`include "sequence_reorder_window_defines.svh"

module sequence_reorder_window import srw_pkg::*; #(
    parameter int WINDOW = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // seq_no, price, quantity, stamp_ns, zero pad
    input  logic [DATA_W-1:0]     i_s_axis_tdata,
    // flag_bits
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_seq_no, out_price, out_quantity, out_stamp_ns, zero pad
    output logic [DATA_W-1:0]     o_m_axis_tdata,
    // status, out_flag_bits
    output logic [OUT_USER_W-1:0] o_m_axis_tuser,
    output logic                  o_m_axis_tlast
);

    localparam int SLOT_W = $clog2(WINDOW);

    t_entry            w_in_pay;
    t_push             w_push;
    logic              w_push_ready;
    logic              w_ram_we;
    logic [SLOT_W-1:0] w_ram_waddr;
    t_entry            w_ram_wdata;
    logic              w_ram_re;
    logic [SLOT_W-1:0] w_ram_raddr;
    t_entry            w_ram_rdata;
    logic              r_out_valid;
    t_result           r_out;

    // Unpack the input word into a ring entry
    always_comb begin
        w_in_pay.valid = 1'b1;
        w_in_pay.price = i_s_axis_tdata[QTY_LSB-1:PRICE_LSB];
        w_in_pay.qty   = i_s_axis_tdata[STAMP_LSB-1:QTY_LSB];
        w_in_pay.stamp = i_s_axis_tdata[FIELDS_W-1:STAMP_LSB];
        w_in_pay.flags = i_s_axis_tuser;
    end

    srw_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_seq        (i_s_axis_tdata[SEQ_W-1:0]),
        .i_pay        (w_in_pay),
        .i_push_ready (w_push_ready),
        .o_push       (w_push),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_re     (w_ram_re),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata)
    );

    srw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Output register: take a new word when empty or being drained
    assign w_push_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push.valid) begin
            r_out <= w_push.res;
        end
    end

    // Pack the result word
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {PAD_W'(0), r_out.stamp, r_out.qty, r_out.price, r_out.seq};
    assign o_m_axis_tuser  = {r_out.flags, r_out.status};
    assign o_m_axis_tlast  = r_out.last;

    // Checks
    `SRW_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
    `SRW_ASSERT(a_drop_is_last, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser[STATUS_W-1:0] != STATUS_RELEASE) |-> o_m_axis_tlast)
    `SRW_ASSERT(a_push_fits, i_clk, i_rst_n, w_push.valid |-> (!r_out_valid || i_m_axis_tready))
    `SRW_ASSERT_RST(a_clear_after_reset, i_clk, !i_rst_n |=> !o_s_axis_tready)

endmodule
